/* design/smpq_pkg.sv */
// Shared types and constants of the stable min priority queue.
// Holds operation, status and controller state codes and the default sizes.
// No dependencies.
package smpq_pkg;

   localparam int SMPQ_DEPTH       = 16;
   localparam int SMPQ_HANDLE_BITS = 16;
   localparam int SMPQ_PRIO_BITS   = 8;

   // Request operation codes; the fourth code does nothing
   typedef enum logic [1:0] {
      MODE_ENQ   = 2'd0,
      MODE_DEQ   = 2'd1,
      MODE_PURGE = 2'd2
   } mode_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Controller states
   typedef enum logic [1:0] {
      S_IDLE,
      S_SEARCH,
      S_FINISH
   } state_type;

   // Per-cell control from the controller
   typedef struct packed {
      logic purge_mode;  // match on handle instead of minimum priority
      logic write_en;    // load the incoming entry
      logic shift_en;    // take the entry of the next cell
   } cell_ctrl_type;

endpackage

/* design/smpq_channels.sv */
// Valid/ready channel interfaces for the queue requests and results.
// Depends on smpq_pkg for default field widths.
interface smpq_req_if import smpq_pkg::*; #(
   parameter int HANDLE_BITS = SMPQ_HANDLE_BITS,
   parameter int PRIO_BITS   = SMPQ_PRIO_BITS
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             mode;
   logic [HANDLE_BITS-1:0] handle;
   logic [PRIO_BITS-1:0]   priority_req;

   modport source (output valid, output mode, output handle, output priority_req,
                   input ready);
   modport sink   (input valid, input mode, input handle, input priority_req,
                   output ready);
endinterface

interface smpq_rsp_if import smpq_pkg::*; #(
   parameter int HANDLE_BITS = SMPQ_HANDLE_BITS,
   parameter int PRIO_BITS   = SMPQ_PRIO_BITS,
   parameter int COUNT_BITS  = $clog2(SMPQ_DEPTH + 1)
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [HANDLE_BITS-1:0] out_handle;
   logic [PRIO_BITS-1:0]   out_priority;
   logic [COUNT_BITS-1:0]  count;
   logic                   is_empty;

   modport source (output valid, output status, output out_handle, output out_priority,
                   output count, output is_empty, input ready);
   modport sink   (input valid, input status, input out_handle, input out_priority,
                   input count, input is_empty, output ready);
endinterface

/* design/smpq_cell.sv */
// One queue slot: holds an entry and forwards the running search candidate.
// Depends on smpq_pkg for the cell control struct.
module smpq_cell import smpq_pkg::*; #(
   parameter int HANDLE_BITS = SMPQ_HANDLE_BITS,
   parameter int PRIO_BITS   = SMPQ_PRIO_BITS,
   parameter int IDX_BITS    = 4,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic                   occupied,
   input  logic [HANDLE_BITS-1:0] key_handle,
   input  logic [HANDLE_BITS-1:0] new_handle,
   input  logic [PRIO_BITS-1:0]   new_prio,
   input  logic [HANDLE_BITS-1:0] next_handle,
   input  logic [PRIO_BITS-1:0]   next_prio,
   input  logic                   cand_found_i,
   input  logic [IDX_BITS-1:0]    cand_pos_i,
   input  logic [HANDLE_BITS-1:0] cand_handle_i,
   input  logic [PRIO_BITS-1:0]   cand_prio_i,
   output logic [HANDLE_BITS-1:0] ent_handle,
   output logic [PRIO_BITS-1:0]   ent_prio,
   output logic                   cand_found_o,
   output logic [IDX_BITS-1:0]    cand_pos_o,
   output logic [HANDLE_BITS-1:0] cand_handle_o,
   output logic [PRIO_BITS-1:0]   cand_prio_o
);

   logic [HANDLE_BITS-1:0] handle_ff, handle_in;
   logic [PRIO_BITS-1:0]   prio_ff, prio_in;
   logic                   found_ff, found_in;
   logic [IDX_BITS-1:0]    pos_ff, pos_in;
   logic [HANDLE_BITS-1:0] chandle_ff, chandle_in;
   logic [PRIO_BITS-1:0]   cprio_ff, cprio_in;
   logic                   take_own;

   // Load a new entry, or shift in the neighbor's entry to close a gap
   always_comb begin
      handle_in = handle_ff;
      prio_in   = prio_ff;
      if (ctrl.write_en) begin
         handle_in = new_handle;
         prio_in   = new_prio;
      end else if (ctrl.shift_en) begin
         handle_in = next_handle;
         prio_in   = next_prio;
      end
   end

   // Replace the candidate: first handle match, or strictly smaller priority
   always_comb begin
      if (ctrl.purge_mode) begin
         take_own = occupied && !cand_found_i && (handle_ff == key_handle);
      end else begin
         take_own = occupied && (!cand_found_i || (prio_ff < cand_prio_i));
      end
      if (take_own) begin
         found_in   = 1'b1;
         pos_in     = IDX_BITS'(INDEX);
         chandle_in = handle_ff;
         cprio_in   = prio_ff;
      end else begin
         found_in   = cand_found_i;
         pos_in     = cand_pos_i;
         chandle_in = cand_handle_i;
         cprio_in   = cand_prio_i;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff  <= handle_in;
      prio_ff    <= prio_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      chandle_ff <= chandle_in;
      cprio_ff   <= cprio_in;
   end

   assign ent_handle    = handle_ff;
   assign ent_prio      = prio_ff;
   assign cand_found_o  = found_ff;
   assign cand_pos_o    = pos_ff;
   assign cand_handle_o = chandle_ff;
   assign cand_prio_o   = cprio_ff;

endmodule

/* design/stable_min_priority_queue_unit.sv */
// Top level of the stable min priority queue: controller, cell chain and result register.
// Depends on smpq_pkg, smpq_channels and smpq_cell.
//
// A bounded queue of up to DEPTH entries kept in arrival order, one entry per cell.
// Enqueue and the unused mode code go straight from transfer to the finish state. Dequeue
// and purge on a non-empty queue first run a search (an empty queue skips it): the
// search candidate moves one cell per cycle along the chain of DEPTH cells, and the
// removal then shifts the tail of the chain down by one. The block handles one
// request at a time; a new request is taken while a result still waits in the output
// register.
module stable_min_priority_queue_unit import smpq_pkg::*; #(
   parameter int DEPTH       = SMPQ_DEPTH,
   parameter int HANDLE_BITS = SMPQ_HANDLE_BITS,
   parameter int PRIO_BITS   = SMPQ_PRIO_BITS
) (
   input logic       clock,
   input logic       reset,
   smpq_req_if.sink  req_if,
   smpq_rsp_if.source rsp_if
);

   localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   state_type              state_ff, state_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    sweep_ff, sweep_in;
   logic [1:0]             mode_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [PRIO_BITS-1:0]   prio_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;
   logic [HANDLE_BITS-1:0] rsp_handle_ff, rsp_handle_in;
   logic [PRIO_BITS-1:0]   rsp_prio_ff, rsp_prio_in;
   logic [CNT_BITS-1:0]    rsp_count_ff;

   logic                   accept;
   logic                   out_free;
   logic                   commit_enq;
   logic                   commit_remove;

   cell_ctrl_type          cell_ctrl [DEPTH];
   logic                   occupied  [DEPTH];
   logic [HANDLE_BITS-1:0] ent_handle [DEPTH];
   logic [PRIO_BITS-1:0]   ent_prio   [DEPTH];
   logic                   cand_found  [DEPTH+1];
   logic [IDX_BITS-1:0]    cand_pos    [DEPTH+1];
   logic [HANDLE_BITS-1:0] cand_handle [DEPTH+1];
   logic [PRIO_BITS-1:0]   cand_prio   [DEPTH+1];

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Latch the request on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_if.mode;
         handle_ff <= req_if.handle;
         prio_ff   <= req_if.priority_req;
      end
   end

   // Sequence: idle, candidate sweep, commit into the result register
   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      count_in      = count_ff;
      req_if.ready  = 1'b0;
      commit_enq    = 1'b0;
      commit_remove = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = ST_OK;
      rsp_handle_in = '0;
      rsp_prio_in   = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               sweep_in = CNT_BITS'(DEPTH - 1);
               if ((req_if.mode == MODE_DEQ || req_if.mode == MODE_PURGE) && count_ff != '0) begin
                  state_in = S_SEARCH;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SEARCH: begin
            sweep_in = sweep_ff - 1'b1;
            if (sweep_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               case (mode_ff) inside
                  MODE_ENQ: begin
                     if (count_ff == CNT_BITS'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        commit_enq = 1'b1;
                        count_in   = count_ff + 1'b1;
                     end
                  end
                  MODE_DEQ, MODE_PURGE: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (!cand_found[DEPTH]) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        commit_remove = 1'b1;
                        count_in      = count_ff - 1'b1;
                        rsp_handle_in = cand_handle[DEPTH];
                        rsp_prio_in   = cand_prio[DEPTH];
                     end
                  end
                  default: begin
                     rsp_status_in = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the result until its transfer
   always_ff @(posedge clock) begin
      if (state_ff == S_FINISH && out_free) begin
         rsp_status_ff <= rsp_status_in;
         rsp_handle_ff <= rsp_handle_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.out_handle   = rsp_handle_ff;
   assign rsp_if.out_priority = rsp_prio_ff;
   assign rsp_if.count        = rsp_count_ff;
   assign rsp_if.is_empty     = (rsp_count_ff == '0);

   // Drive each cell: occupancy, tail write, shift above the removed slot
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         occupied[i]            = CNT_BITS'(i) < count_ff;
         cell_ctrl[i].purge_mode = (mode_ff == MODE_PURGE);
         cell_ctrl[i].write_en  = commit_enq && (CNT_BITS'(i) == count_ff);
         cell_ctrl[i].shift_en  = commit_remove && (IDX_BITS'(i) >= cand_pos[DEPTH]);
      end
   end

   assign cand_found[0]  = 1'b0;
   assign cand_pos[0]    = '0;
   assign cand_handle[0] = '0;
   assign cand_prio[0]   = '0;

   // Chain of cells, head at index zero
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [HANDLE_BITS-1:0] nxt_handle;
      logic [PRIO_BITS-1:0]   nxt_prio;
      if (g == DEPTH - 1) begin : g_tail
         assign nxt_handle = ent_handle[g];
         assign nxt_prio   = ent_prio[g];
      end else begin : g_body
         assign nxt_handle = ent_handle[g+1];
         assign nxt_prio   = ent_prio[g+1];
      end
      smpq_cell #(
         .HANDLE_BITS (HANDLE_BITS),
         .PRIO_BITS   (PRIO_BITS),
         .IDX_BITS    (IDX_BITS),
         .INDEX       (g)
      ) u_cell (
         .clock         (clock),
         .ctrl          (cell_ctrl[g]),
         .occupied      (occupied[g]),
         .key_handle    (handle_ff),
         .new_handle    (handle_ff),
         .new_prio      (prio_ff),
         .next_handle   (nxt_handle),
         .next_prio     (nxt_prio),
         .cand_found_i  (cand_found[g]),
         .cand_pos_i    (cand_pos[g]),
         .cand_handle_i (cand_handle[g]),
         .cand_prio_i   (cand_prio[g]),
         .ent_handle    (ent_handle[g]),
         .ent_prio      (ent_prio[g]),
         .cand_found_o  (cand_found[g+1]),
         .cand_pos_o    (cand_pos[g+1]),
         .cand_handle_o (cand_handle[g+1]),
         .cand_prio_o   (cand_prio[g+1])
      );
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count above depth");

   a_deq_finds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && mode_ff == MODE_DEQ && count_ff != '0) |-> cand_found[DEPTH])
      else $error("dequeue on non-empty queue found no candidate");

   a_remove_count: assert property (@(posedge clock) disable iff (reset)
      commit_remove |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("removal did not decrement count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("controller idle right after a transfer");
`endif

endmodule
